// ===== hdl/lcdns_pkg.sv =====
// Package for the character LCD nibble sequencer.
// Holds the opcode and register codes, the command constants, the init tables
// and the structs shared between the modules. No dependencies.
`default_nettype none

package lcdns_pkg;

  typedef enum logic [2:0] {
    OP_DATA     = 3'd0,
    OP_COMMAND  = 3'd1,
    OP_LOCATE   = 3'd2,
    OP_CLEAR    = 3'd3,
    OP_CONTROL  = 3'd4,
    OP_FUNCTION = 3'd5,
    OP_ENTRY    = 3'd6,
    OP_INIT     = 3'd7
  } opcode_t;

  typedef enum logic [1:0] {
    REG_ENABLE_PULSE = 2'd0,
    REG_BYTE_SETTLE  = 2'd1,
    REG_CLEAR_WAIT   = 2'd2
  } reg_index_t;

  localparam int unsigned CfgAddrWidth = 4;
  localparam int unsigned CfgDataWidth = 32;

  localparam logic [7:0] LINE1_BASE   = 8'h80;
  localparam logic [7:0] LINE2_BASE   = 8'hC0;
  localparam logic [7:0] CMD_FUNCTION = 8'h20;
  localparam logic [7:0] CMD_CONTROL  = 8'h08;
  localparam logic [7:0] CMD_ENTRY    = 8'h04;
  localparam logic [7:0] CMD_CLEAR    = 8'h01;

  localparam logic [15:0] POWER_ON_US = 16'd20000;

  localparam int unsigned StepWidth = 5;
  // Step numbers of the final event of a single byte and of the init request.
  localparam logic [StepWidth-1:0] BYTE_LAST_STEP = 5'd3;
  localparam logic [StepWidth-1:0] INIT_LAST_STEP = 5'd24;
  // Events that the four lone init nibbles occupy after the power-on event.
  localparam logic [StepWidth-1:0] INIT_NIBBLE_EVENTS = 5'd8;
  localparam logic [1:0]           INIT_CLEAR_SLOT    = 2'd2;

  typedef struct packed {
    logic [7:0]  enable_pulse;
    logic [9:0]  byte_settle;
    logic [13:0] clear_wait;
  } cfg_t;

  typedef struct packed {
    logic                 load;
    logic                 emit;
    logic [StepWidth-1:0] step;
  } dp_cmd_t;

  typedef struct packed {
    logic skip;
    logic slot_free;
    logic last;
  } dp_status_t;

  function automatic logic [3:0] init_nibble(input logic [1:0] idx);
    logic [3:0] nib;
    case (idx)
      2'd3:    nib = 4'b0010;
      default: nib = 4'b0011;
    endcase
    return nib;
  endfunction

  function automatic logic [15:0] init_extra(input logic [1:0] idx);
    logic [15:0] us;
    case (idx)
      2'd0:    us = 16'd10000;
      2'd1:    us = 16'd15000;
      default: us = 16'd80;
    endcase
    return us;
  endfunction

  function automatic logic [7:0] init_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = CMD_FUNCTION | 8'h08;
      2'd1:    b = CMD_CONTROL | 8'h03;
      2'd2:    b = CMD_CLEAR;
      default: b = CMD_ENTRY | 8'h02;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/lcdns_if.sv =====
// Valid/ready channel interfaces of the LCD nibble sequencer: the request
// channel and the pin event channel. No dependencies.
`default_nettype none

interface lcdns_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] opcode;
  logic [7:0] data_byte;
  logic       row;
  logic [5:0] column;
  logic [2:0] flags;

  modport source (output valid, opcode, data_byte, row, column, flags, input ready);
  modport sink (input valid, opcode, data_byte, row, column, flags, output ready);
endinterface

interface lcdns_out_if;
  logic        valid;
  logic        ready;
  logic        reg_select;
  logic [3:0]  nibble;
  logic        enable;
  logic [15:0] hold_us;
  logic        last;

  modport source (output valid, reg_select, nibble, enable, hold_us, last, input ready);
  modport sink (input valid, reg_select, nibble, enable, hold_us, last, output ready);
endinterface

`default_nettype wire

// ===== hdl/lcdns_cfg.sv =====
// APB-style register block holding the three timing registers.
// Depends on lcdns_pkg.
`default_nettype none

module lcdns_cfg (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [lcdns_pkg::CfgAddrWidth-1:0] paddr,
  input  wire logic [lcdns_pkg::CfgDataWidth-1:0] pwdata,
  output logic      [lcdns_pkg::CfgDataWidth-1:0] prdata,
  output logic                                   pready,
  output lcdns_pkg::cfg_t                        cfg
);
  import lcdns_pkg::*;

  logic [7:0]  enable_pulse_r, enable_pulse_nxt;
  logic [9:0]  byte_settle_r, byte_settle_nxt;
  logic [13:0] clear_wait_r, clear_wait_nxt;
  logic        wr_en;
  reg_index_t  idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = reg_index_t'(paddr[3:2]);

  always_comb begin
    enable_pulse_nxt = enable_pulse_r;
    byte_settle_nxt  = byte_settle_r;
    clear_wait_nxt   = clear_wait_r;
    if (wr_en) begin
      case (idx)
        REG_ENABLE_PULSE: enable_pulse_nxt = pwdata[7:0];
        REG_BYTE_SETTLE:  byte_settle_nxt  = pwdata[9:0];
        REG_CLEAR_WAIT:   clear_wait_nxt   = pwdata[13:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_pulse_r <= 8'd6;
      byte_settle_r  <= 10'd100;
      clear_wait_r   <= 14'd5000;
    end else begin
      enable_pulse_r <= enable_pulse_nxt;
      byte_settle_r  <= byte_settle_nxt;
      clear_wait_r   <= clear_wait_nxt;
    end
  end

  always_comb begin
    case (idx)
      REG_ENABLE_PULSE: prdata = {24'd0, enable_pulse_r};
      REG_BYTE_SETTLE:  prdata = {22'd0, byte_settle_r};
      REG_CLEAR_WAIT:   prdata = {18'd0, clear_wait_r};
      default:          prdata = '0;
    endcase
  end

  assign cfg.enable_pulse = enable_pulse_r;
  assign cfg.byte_settle  = byte_settle_r;
  assign cfg.clear_wait   = clear_wait_r;

endmodule

`default_nettype wire

// ===== hdl/lcdns_ctrl.sv =====
// Controller of the LCD nibble sequencer: accepts requests and walks the
// event step counter. Depends on lcdns_pkg.
`default_nettype none

module lcdns_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire lcdns_pkg::dp_status_t status,
  output lcdns_pkg::dp_cmd_t         cmd
);
  import lcdns_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } state_t;

  state_t               state_r, state_nxt;
  logic [StepWidth-1:0] step_r, step_nxt;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    in_ready  = 1'b0;
    cmd.load  = 1'b0;
    cmd.emit  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          step_nxt = '0;
          // A zero data character produces no events at all.
          if (!status.skip) begin
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (status.slot_free) begin
          cmd.emit = 1'b1;
          step_nxt = step_r + 1'b1;
          if (status.last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign cmd.step = step_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/lcdns_dp.sv =====
// Datapath of the LCD nibble sequencer: request decode, event generation
// per step and the output event register. Depends on lcdns_pkg.
`default_nettype none

module lcdns_dp #(
  parameter int unsigned LINE_COLUMNS = 40
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic [2:0]            in_opcode,
  input  wire logic [7:0]            in_data_byte,
  input  wire logic                  in_row,
  input  wire logic [5:0]            in_column,
  input  wire logic [2:0]            in_flags,
  input  wire lcdns_pkg::cfg_t       cfg,
  input  wire lcdns_pkg::dp_cmd_t    cmd,
  output lcdns_pkg::dp_status_t      status,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic                       out_reg_select,
  output logic [3:0]                 out_nibble,
  output logic                       out_enable,
  output logic [15:0]                out_hold_us,
  output logic                       out_last
);
  import lcdns_pkg::*;

  localparam logic [5:0] MaxColumn = 6'(LINE_COLUMNS - 1);

  // Request held for the duration of its events.
  logic [7:0] byte_r, byte_nxt;
  logic       rs_r, rs_nxt;
  logic       clr_r, clr_nxt;
  logic       init_r, init_nxt;

  logic        valid_r, valid_nxt;
  logic        ev_rs_r;
  logic [3:0]  ev_nibble_r;
  logic        ev_enable_r;
  logic [15:0] ev_hold_r;
  logic        ev_last_r;

  opcode_t    op;
  logic [5:0] col_sat;

  logic [StepWidth-1:0] k, kb;
  logic [3:0]           j;
  logic [7:0]           cur_byte;
  logic                 cur_clr;
  logic [3:0]           ev_nibble;
  logic                 ev_enable;
  logic [15:0]          ev_hold;
  logic                 ev_last;
  logic [15:0]          settle_sum;

  assign op      = opcode_t'(in_opcode);
  assign col_sat = (in_column > MaxColumn) ? MaxColumn : in_column;

  always_comb begin
    byte_nxt = byte_r;
    rs_nxt   = rs_r;
    clr_nxt  = clr_r;
    init_nxt = init_r;
    if (cmd.load) begin
      byte_nxt = in_data_byte;
      rs_nxt   = 1'b0;
      clr_nxt  = 1'b0;
      init_nxt = 1'b0;
      case (op)
        OP_DATA:     rs_nxt = 1'b1;
        OP_COMMAND:  byte_nxt = in_data_byte;
        OP_LOCATE:   byte_nxt = (in_row ? LINE2_BASE : LINE1_BASE) + {2'b00, col_sat};
        OP_CLEAR: begin
          byte_nxt = CMD_CLEAR;
          clr_nxt  = 1'b1;
        end
        OP_CONTROL:  byte_nxt = CMD_CONTROL | {5'd0, in_flags};
        OP_FUNCTION: byte_nxt = CMD_FUNCTION | {4'd0, in_flags[1:0], 2'b00};
        OP_ENTRY:    byte_nxt = CMD_ENTRY | {6'd0, in_flags[1:0]};
        OP_INIT:     init_nxt = 1'b1;
        default:     init_nxt = 1'b1;
      endcase
    end
  end

  // Event for the current step. Init steps past the lone nibbles and every
  // other request share the four-event byte pattern.
  always_comb begin
    k          = cmd.step - 1'b1;
    kb         = k - INIT_NIBBLE_EVENTS;
    j          = cmd.step[3:0];
    cur_byte   = byte_r;
    cur_clr    = clr_r;
    if (init_r) begin
      j        = kb[3:0];
      cur_byte = init_byte(kb[3:2]);
      cur_clr  = (kb[3:2] == INIT_CLEAR_SLOT);
    end
    settle_sum = {6'd0, cfg.byte_settle} + (cur_clr ? {2'd0, cfg.clear_wait} : 16'd0);
    ev_nibble  = j[1] ? cur_byte[3:0] : cur_byte[7:4];
    ev_enable  = ~j[0];
    ev_hold    = {8'd0, cfg.enable_pulse} + ((j[1] & j[0]) ? settle_sum : 16'd0);
    if (init_r) begin
      if (cmd.step == '0) begin
        ev_nibble = 4'd0;
        ev_enable = 1'b0;
        ev_hold   = POWER_ON_US;
      end else if (k < INIT_NIBBLE_EVENTS) begin
        ev_nibble = init_nibble(k[2:1]);
        ev_enable = ~k[0];
        ev_hold   = {8'd0, cfg.enable_pulse} + (k[0] ? init_extra(k[2:1]) : 16'd0);
      end
    end
    ev_last = (cmd.step == (init_r ? INIT_LAST_STEP : BYTE_LAST_STEP));
  end

  always_comb begin
    valid_nxt = valid_r;
    if (cmd.emit) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    rs_r   <= rs_nxt;
    clr_r  <= clr_nxt;
    init_r <= init_nxt;
    if (cmd.emit) begin
      ev_rs_r     <= rs_r;
      ev_nibble_r <= ev_nibble;
      ev_enable_r <= ev_enable;
      ev_hold_r   <= ev_hold;
      ev_last_r   <= ev_last;
    end
  end

  assign status.skip      = (op == OP_DATA) && (in_data_byte == 8'd0);
  assign status.slot_free = ~valid_r | out_ready;
  assign status.last      = ev_last;

  assign out_valid      = valid_r;
  assign out_reg_select = ev_rs_r;
  assign out_nibble     = ev_nibble_r;
  assign out_enable     = ev_enable_r;
  assign out_hold_us    = ev_hold_r;
  assign out_last       = ev_last_r;

endmodule

`default_nettype wire

// ===== hdl/char_lcd_nibble_sequencer.sv =====
// Top level of the character LCD nibble sequencer (4-bit display interface).
// Depends on lcdns_pkg, lcdns_if, lcdns_cfg, lcdns_ctrl and lcdns_dp.
//
// Usage: each transaction on in_ch is one display request (opcode, data_byte,
// row, column, flags). The block answers with a burst of pin events on
// out_ch, each giving RS, DB7..DB4, E and a hold time in microseconds; the
// final event of a request carries last. A byte request gives 4 events, the
// init request 25, and a data request with a zero character none.
// An accepted request is held in the datapath while the controller steps
// through its events, each of which is registered in the output register.
// Throughput: one event per cycle while out_ch is ready, set by the step
// counter of the controller. A new request is taken once the final event
// of the previous one sits in the output register.
// When the receiver stalls, the current event holds in the output register
// and the step counter waits. Reset clears the controller and the output
// valid and loads the timing registers with 6, 100 and 5000 us. The timing
// registers sit on the cfg_ APB port at byte addresses 0, 4 and 8. The user
// must write them only while the block is idle; the block does not enforce it.
`default_nettype none

module char_lcd_nibble_sequencer #(
  parameter int unsigned LINE_COLUMNS = 40
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  lcdns_in_if.sink                                in_ch,
  lcdns_out_if.source                             out_ch,
  input  wire logic                               cfg_psel,
  input  wire logic                               cfg_penable,
  input  wire logic                               cfg_pwrite,
  input  wire logic [lcdns_pkg::CfgAddrWidth-1:0] cfg_paddr,
  input  wire logic [lcdns_pkg::CfgDataWidth-1:0] cfg_pwdata,
  output logic      [lcdns_pkg::CfgDataWidth-1:0] cfg_prdata,
  output logic                                    cfg_pready
);
  import lcdns_pkg::*;

  cfg_t       cfg;
  dp_cmd_t    cmd;
  dp_status_t status;

  lcdns_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  lcdns_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  lcdns_dp #(
    .LINE_COLUMNS (LINE_COLUMNS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_opcode      (in_ch.opcode),
    .in_data_byte   (in_ch.data_byte),
    .in_row         (in_ch.row),
    .in_column      (in_ch.column),
    .in_flags       (in_ch.flags),
    .cfg            (cfg),
    .cmd            (cmd),
    .status         (status),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_reg_select (out_ch.reg_select),
    .out_nibble     (out_ch.nibble),
    .out_enable     (out_ch.enable),
    .out_hold_us    (out_ch.hold_us),
    .out_last       (out_ch.last)
  );

  // No event is produced in a cycle in which a request can be taken.
  assert property (@(posedge clk) disable iff (!rst_n) in_ch.ready |-> !cmd.emit)
    else $error("event emitted while accepting requests");

  // A request that yields events blocks the input until its final event.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && !status.skip) |=> !in_ch.ready)
    else $error("input ready right after a request with events");

  // Once the final event is loaded the block is ready for the next request.
  assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && status.last) |=> (in_ch.ready && out_ch.valid && out_ch.last))
    else $error("final event not followed by idle");

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for char_lcd_nibble_sequencer: directed and random
// display requests, with every pin event checked against an in-bench predictor.
// Depends on lcdns_pkg, the channel interfaces in lcdns_if and the sequencer RTL.

module tb;
  import lcdns_pkg::*;

  localparam int unsigned COLUMNS = 40;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned LONG_STALL = 400;
  localparam int unsigned DRAIN_CYCLES = 12;
  localparam int unsigned ITEMS_PER_PHASE = 28;
  localparam int unsigned RANDOM_PHASES = 4;
  localparam int unsigned MAX_REPORTS = 10;

  localparam logic [7:0] LCD_LINE1 = 8'h80;
  localparam logic [7:0] LCD_LINE2 = 8'hC0;
  localparam logic [7:0] LCD_FUNCTION = 8'h20;
  localparam logic [7:0] LCD_DISP_CTRL = 8'h08;
  localparam logic [7:0] LCD_ENTRY = 8'h04;
  localparam logic [7:0] LCD_CLEAR = 8'h01;
  localparam logic [15:0] POWER_ON_HOLD = 16'd20000;

  typedef enum int unsigned {
    RX_ALWAYS,
    RX_COIN,
    RX_PERIODIC,
    RX_MOSTLY
  } rx_mode_t;

  typedef struct {
    opcode_t    op;
    logic [7:0] data_byte;
    logic       row;
    logic [5:0] column;
    logic [2:0] flags;
  } lcd_req_t;

  typedef struct {
    logic        reg_select;
    logic [3:0]  nibble;
    logic        enable;
    logic [15:0] hold_us;
    logic        last;
  } pin_event_t;

  logic clk;
  logic rst_n;
  logic                    cfg_psel;
  logic                    cfg_penable;
  logic                    cfg_pwrite;
  logic [CfgAddrWidth-1:0] cfg_paddr;
  logic [CfgDataWidth-1:0] cfg_pwdata;
  logic [CfgDataWidth-1:0] cfg_prdata;
  logic                    cfg_pready;

  lcdns_in_if  in_ch ();
  lcdns_out_if out_ch ();

  char_lcd_nibble_sequencer #(
    .LINE_COLUMNS(COLUMNS)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  // Timing registers as the block should hold them.
  logic [7:0]  enable_pulse_us = 8'd6;
  logic [9:0]  byte_settle_us = 10'd100;
  logic [13:0] clear_wait_us = 14'd5000;

  lcd_req_t    pending_reqs[$];
  pin_event_t  pin_events_due[$];
  int unsigned mismatches = 0;
  int unsigned requests_taken = 0;
  int unsigned init_taken = 0;
  int unsigned silent_taken = 0;
  int unsigned events_checked = 0;
  int unsigned timing_settings = 1;
  int unsigned stall_reqs = 0;
  int unsigned cycle_count = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic string fmt_event(input pin_event_t e);
    return $sformatf("rs=%0d nib=%h en=%0d hold=%0d last=%0d",
                     e.reg_select, e.nibble, e.enable, e.hold_us, e.last);
  endfunction

  task automatic note_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("[%0t] mismatch: %s", $realtime, what);
    end
  endtask

  task automatic push_event(input logic rs, input logic [3:0] nib, input logic en,
                            input logic [15:0] hold);
    pin_event_t ev;
    ev.reg_select = rs;
    ev.nibble = nib;
    ev.enable = en;
    ev.hold_us = hold;
    ev.last = 1'b0;
    pin_events_due.push_back(ev);
  endtask

  task automatic push_nibble(input logic rs, input logic [3:0] nib, input logic [15:0] extra);
    push_event(rs, nib, 1'b1, 16'(enable_pulse_us));
    push_event(rs, nib, 1'b0, 16'(enable_pulse_us) + extra);
  endtask

  task automatic push_byte(input logic rs, input logic [7:0] b, input logic [15:0] extra);
    push_nibble(rs, b[7:4], 16'd0);
    push_nibble(rs, b[3:0], 16'(byte_settle_us) + extra);
  endtask

  task automatic predict_pin_events(input lcd_req_t req);
    int unsigned before_cnt;
    logic [5:0] col;
    before_cnt = pin_events_due.size();
    case (req.op)
      OP_DATA: begin
        if (req.data_byte != 8'd0) push_byte(1'b1, req.data_byte, 16'd0);
      end
      OP_COMMAND: push_byte(1'b0, req.data_byte, 16'd0);
      OP_LOCATE: begin
        // Columns past the end of the line stick at the last column.
        col = (req.column > COLUMNS - 1) ? 6'(COLUMNS - 1) : req.column;
        push_byte(1'b0, (req.row ? LCD_LINE2 : LCD_LINE1) + {2'b00, col}, 16'd0);
      end
      OP_CLEAR: push_byte(1'b0, LCD_CLEAR, 16'(clear_wait_us));
      OP_CONTROL: push_byte(1'b0, LCD_DISP_CTRL | {5'd0, req.flags}, 16'd0);
      OP_FUNCTION: push_byte(1'b0, LCD_FUNCTION | {4'd0, req.flags[1:0], 2'b00}, 16'd0);
      OP_ENTRY: push_byte(1'b0, LCD_ENTRY | {6'd0, req.flags[1:0]}, 16'd0);
      OP_INIT: begin
        push_event(1'b0, 4'h0, 1'b0, POWER_ON_HOLD);
        push_nibble(1'b0, 4'h3, 16'd10000);
        push_nibble(1'b0, 4'h3, 16'd15000);
        push_nibble(1'b0, 4'h3, 16'd80);
        push_nibble(1'b0, 4'h2, 16'd80);
        push_byte(1'b0, LCD_FUNCTION | 8'h08, 16'd0);
        push_byte(1'b0, LCD_DISP_CTRL | 8'h03, 16'd0);
        push_byte(1'b0, LCD_CLEAR, 16'(clear_wait_us));
        push_byte(1'b0, LCD_ENTRY | 8'h02, 16'd0);
      end
      default: ;
    endcase
    if (pin_events_due.size() > before_cnt) begin
      pin_events_due[pin_events_due.size() - 1].last = 1'b1;
    end
  endtask

  function automatic lcd_req_t rand_req();
    lcd_req_t r;
    r.op = ($urandom_range(0, 11) == 0) ? OP_INIT : opcode_t'($urandom_range(0, 6));
    r.data_byte = ($urandom_range(0, 15) == 0) ? 8'd0 : 8'($urandom);
    r.row = 1'($urandom);
    r.column = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(40, 63))
                                           : 6'($urandom_range(0, 39));
    r.flags = 3'($urandom);
    return r;
  endfunction

  task automatic queue_req(input opcode_t op, input logic [7:0] data_byte, input logic row,
                           input logic [5:0] column, input logic [2:0] flags);
    lcd_req_t r;
    r.op = op;
    r.data_byte = data_byte;
    r.row = row;
    r.column = column;
    r.flags = flags;
    pending_reqs.push_back(r);
  endtask

  // Returns once every request is taken and every predicted event has come out.
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_reqs.size() != 0 || in_ch.valid || pin_events_due.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic apb_access(input reg_index_t idx, input logic wr,
                            input logic [CfgDataWidth-1:0] wdata,
                            output logic [CfgDataWidth-1:0] rdata);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= wr;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk);
    while (!cfg_pready);
    rdata = cfg_prdata;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  task automatic set_timing(input logic [7:0] pulse, input logic [9:0] settle,
                            input logic [13:0] clr);
    logic [CfgDataWidth-1:0] regval[3];
    logic [CfgDataWidth-1:0] rd;
    int i;
    regval[0] = {24'd0, pulse};
    regval[1] = {22'd0, settle};
    regval[2] = {18'd0, clr};
    for (i = 0; i < 3; i++) begin
      apb_access(reg_index_t'(i), 1'b1, regval[i], rd);
      apb_access(reg_index_t'(i), 1'b0, '0, rd);
      if (rd !== regval[i]) begin
        note_mismatch($sformatf("register %0d read back: expected %0d, got %0d",
                                i, regval[i], rd));
      end
    end
    enable_pulse_us = pulse;
    byte_settle_us = settle;
    clear_wait_us = clr;
    timing_settings++;
  endtask

  // Request driver: bursts of random length with random gaps between them.
  lcd_req_t    req_on_bus;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predict_pin_events(req_on_bus);
        requests_taken++;
        if (req_on_bus.op == OP_INIT) init_taken++;
        if (req_on_bus.op == OP_DATA && req_on_bus.data_byte == 8'd0) silent_taken++;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 16);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 24);
        end
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_ch.valid <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          req_on_bus = pending_reqs.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.opcode <= req_on_bus.op;
          in_ch.data_byte <= req_on_bus.data_byte;
          in_ch.row <= req_on_bus.row;
          in_ch.column <= req_on_bus.column;
          in_ch.flags <= req_on_bus.flags;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Event receiver: switches between stall patterns, and holds off for a long
  // stretch whenever the stimulus asks for it.
  rx_mode_t    rx_mode = RX_ALWAYS;
  int unsigned mode_left = 0;
  int unsigned stall_left = 0;
  int unsigned stall_done = 0;
  int unsigned rx_tick = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      mode_left = 0;
      stall_left = 0;
    end else begin
      rx_tick++;
      if (stall_done != stall_reqs) begin
        stall_done = stall_reqs;
        stall_left = LONG_STALL;
      end
      if (mode_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(10, 150);
      end else begin
        mode_left--;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_ALWAYS:   out_ch.ready <= 1'b1;
          RX_COIN:     out_ch.ready <= 1'($urandom);
          RX_PERIODIC: out_ch.ready <= (rx_tick % 4 == 0);
          default:     out_ch.ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // Event monitor.
  always @(posedge clk) begin
    pin_event_t got;
    pin_event_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.reg_select = out_ch.reg_select;
      got.nibble = out_ch.nibble;
      got.enable = out_ch.enable;
      got.hold_us = out_ch.hold_us;
      got.last = out_ch.last;
      if (pin_events_due.size() == 0) begin
        note_mismatch({"event with none expected: ", fmt_event(got)});
      end else begin
        want = pin_events_due.pop_front();
        events_checked++;
        if (got.reg_select !== want.reg_select || got.nibble !== want.nibble ||
            got.enable !== want.enable || got.hold_us !== want.hold_us ||
            got.last !== want.last) begin
          note_mismatch({"expected ", fmt_event(want), ", got ", fmt_event(got)});
        end
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timed out after %0d cycles with %0d events outstanding.",
             cycle_count, pin_events_due.size());
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int unsigned phase;
    int unsigned counted;
    lcd_req_t r;

    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.opcode = OP_DATA;
    in_ch.data_byte = 8'd0;
    in_ch.row = 1'b0;
    in_ch.column = 6'd0;
    in_ch.flags = 3'd0;
    out_ch.ready = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed requests under the reset timing.
    queue_req(OP_DATA, 8'h00, 1'b0, 6'd0, 3'd0);
    queue_req(OP_DATA, 8'hFF, 1'b1, 6'd63, 3'd7);
    queue_req(OP_DATA, 8'h41, 1'b0, 6'd0, 3'd0);
    queue_req(OP_DATA, 8'h01, 1'b0, 6'd0, 3'd0);
    queue_req(OP_COMMAND, 8'h00, 1'b0, 6'd0, 3'd0);
    queue_req(OP_COMMAND, 8'hFF, 1'b0, 6'd0, 3'd0);
    queue_req(OP_LOCATE, 8'h00, 1'b0, 6'd0, 3'd0);
    queue_req(OP_LOCATE, 8'h00, 1'b1, 6'd39, 3'd0);
    queue_req(OP_LOCATE, 8'h00, 1'b1, 6'd40, 3'd0);
    queue_req(OP_LOCATE, 8'h00, 1'b0, 6'd63, 3'd0);
    queue_req(OP_CLEAR, 8'h00, 1'b0, 6'd0, 3'd0);
    queue_req(OP_CONTROL, 8'h00, 1'b0, 6'd0, 3'd0);
    queue_req(OP_CONTROL, 8'h00, 1'b0, 6'd0, 3'd7);
    queue_req(OP_FUNCTION, 8'h00, 1'b0, 6'd0, 3'd0);
    queue_req(OP_FUNCTION, 8'h00, 1'b0, 6'd0, 3'd3);
    queue_req(OP_FUNCTION, 8'h00, 1'b0, 6'd0, 3'd4);
    queue_req(OP_ENTRY, 8'h00, 1'b0, 6'd0, 3'd0);
    queue_req(OP_ENTRY, 8'h00, 1'b0, 6'd0, 3'd7);
    queue_req(OP_INIT, 8'h00, 1'b0, 6'd0, 3'd0);
    wait_drained();

    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: set_timing(8'd1, 10'd0, 14'd0);
        1: set_timing(8'd255, 10'd1023, 14'd16383);
        default: set_timing(8'($urandom_range(1, 255)), 10'($urandom_range(0, 1023)),
                            14'($urandom_range(0, 16383)));
      endcase
      counted = 0;
      while (counted < ITEMS_PER_PHASE) begin
        r = rand_req();
        pending_reqs.push_back(r);
        if (!(r.op == OP_DATA && r.data_byte == 8'd0)) counted++;
      end
      // Hold the receiver off while requests keep coming, so the block backs up.
      if (phase == 1) stall_reqs++;
      wait_drained();
    end

    if (pin_events_due.size() != 0) begin
      note_mismatch($sformatf("%0d expected events never came", pin_events_due.size()));
    end
    $display("Covered %0d requests (%0d init, %0d with no events) under %0d timing settings.",
             requests_taken, init_taken, silent_taken, timing_settings);
    $display("Checked %0d pin events in %0d cycles, %0d mismatches.",
             events_checked, cycle_count, mismatches);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
